// ===== rtl/core/bfd_pkg.sv =====
`timescale 1ns / 1ps

package bfd_pkg;

  // Bytes in one frame header; bytes past the stored fields are padding.
  localparam int unsigned HEADER_BYTES    = 28;
  // Bytes that carry header fields and are kept.
  localparam int unsigned HDR_STORE_BYTES = 28;
  localparam int unsigned HDR_POS_W       = $clog2(HEADER_BYTES);
  localparam int unsigned HDR_IDX_W       = $clog2(HDR_STORE_BYTES);
  localparam int unsigned LEN_OFFSET      = 24;

  localparam logic [HDR_POS_W-1:0] HDR_LAST_POS  = HDR_POS_W'(HEADER_BYTES - 1);
  localparam logic [HDR_POS_W-1:0] HDR_STORE_END = HDR_POS_W'(HDR_STORE_BYTES);

  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_PAYLOAD  = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_HEADER  = 2'b01,
    ST_PAYLOAD = 2'b10
  } state_e;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] protocol_version;
    logic [15:0] frame_type;
    logic [63:0] timestamp_ns;
    logic [63:0] sequence_number;
    logic [31:0] payload_length;
  } hdr_fields_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/bfd_hdr_store.sv =====
`timescale 1ns / 1ps

module bfd_hdr_store (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [bfd_pkg::HDR_POS_W-1:0] wr_pos_i,
  input  logic [7:0]                    wr_byte_i,
  output bfd_pkg::hdr_fields_t          fields_o,
  output logic [31:0]                   len_next_o
);

  logic [7:0]                    hdr_q [bfd_pkg::HDR_STORE_BYTES];
  logic [bfd_pkg::HDR_IDX_W-1:0] wr_idx;

  assign wr_idx = wr_pos_i[bfd_pkg::HDR_IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      hdr_q[wr_idx] <= wr_byte_i;
    end
  end

  assign fields_o.magic_word       = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
  assign fields_o.protocol_version = {hdr_q[5], hdr_q[4]};
  assign fields_o.frame_type       = {hdr_q[7], hdr_q[6]};
  assign fields_o.timestamp_ns     = {hdr_q[15], hdr_q[14], hdr_q[13], hdr_q[12],
                                      hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
  assign fields_o.sequence_number  = {hdr_q[23], hdr_q[22], hdr_q[21], hdr_q[20],
                                      hdr_q[19], hdr_q[18], hdr_q[17], hdr_q[16]};
  assign fields_o.payload_length   = {hdr_q[27], hdr_q[26], hdr_q[25], hdr_q[24]};

  // The length byte being written in this cycle is forwarded, so the length
  // check can run on the item that completes the header.
  for (genvar i = 0; i < 4; i++) begin : g_len
    assign len_next_o[8*i +: 8] =
        (wr_en_i && (wr_pos_i == bfd_pkg::HDR_POS_W'(bfd_pkg::LEN_OFFSET + i))) ?
        wr_byte_i : hdr_q[bfd_pkg::LEN_OFFSET + i];
  end

endmodule

// ===== rtl/core/bfd_frame_ctrl.sv =====
`timescale 1ns / 1ps

module bfd_frame_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          acc_i,
  input  logic [7:0]                    in_byte_i,
  input  logic [31:0]                   len_next_i,
  output logic                          hdr_we_o,
  output logic [bfd_pkg::HDR_POS_W-1:0] hdr_pos_o,
  output bfd_pkg::res_t                 res_o
);

  bfd_pkg::state_e               state_q, state_d;
  logic [bfd_pkg::HDR_POS_W-1:0] pos_q, pos_d;
  logic [31:0]                   rem_q, rem_d;
  logic [31:0]                   max_len_q;
  logic                          hdr_done;
  logic                          oversize;
  logic                          zero_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= bfd_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign hdr_done  = (state_q == bfd_pkg::ST_HEADER) && (pos_q == bfd_pkg::HDR_LAST_POS);
  assign oversize  = len_next_i > max_len_q;
  assign zero_len  = len_next_i == 32'd0;
  assign hdr_pos_o = pos_q;
  assign hdr_we_o  = acc_i && (state_q == bfd_pkg::ST_HEADER) &&
                     (pos_q < bfd_pkg::HDR_STORE_END);

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    res_o      = '0;
    res_o.kind = bfd_pkg::KIND_HEADER;
    case (state_q)
      bfd_pkg::ST_HEADER: begin
        if (acc_i) begin
          if (hdr_done) begin
            pos_d       = '0;
            res_o.valid = 1'b1;
            if (oversize) begin
              res_o.kind = bfd_pkg::KIND_OVERSIZE;
              res_o.last = 1'b1;
            end else if (zero_len) begin
              res_o.last = 1'b1;
            end else begin
              state_d = bfd_pkg::ST_PAYLOAD;
              rem_d   = len_next_i;
            end
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      bfd_pkg::ST_PAYLOAD: begin
        if (acc_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = bfd_pkg::KIND_PAYLOAD;
          res_o.data  = in_byte_i;
          rem_d       = rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            res_o.last = 1'b1;
            state_d    = bfd_pkg::ST_HEADER;
            pos_d      = '0;
          end
        end
      end
      default: begin
        state_d = bfd_pkg::ST_HEADER;
        pos_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfd_pkg::ST_HEADER;
      pos_q   <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
    end
  end

`ifndef SYNTHESIS
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfd_pkg::ST_PAYLOAD) |-> (rem_q != 32'd0))
    else $error("payload state with no bytes left");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfd_pkg::ST_HEADER) |-> (pos_q <= bfd_pkg::HDR_LAST_POS))
    else $error("header position past the header");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && (state_q == bfd_pkg::ST_PAYLOAD) && (rem_q == 32'd1))
    |=> ((state_q == bfd_pkg::ST_HEADER) && (pos_q == '0)))
    else $error("final payload item did not return to header hunt");

  a_oversize_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && hdr_done && oversize)
    |=> ((state_q == bfd_pkg::ST_HEADER) && (pos_q == '0)))
    else $error("oversize header entered payload");
`endif

endmodule

// ===== rtl/core/bfd_out_reg.sv =====
`timescale 1ns / 1ps

module bfd_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bfd_pkg::res_t res_i,
  input  logic          out_stall_i,
  output logic          hold_o,
  output logic          out_valid_o,
  output logic [1:0]    result_kind_o,
  output logic [7:0]    data_byte_o,
  output logic          last_o
);

  logic            valid_q;
  bfd_pkg::kind_e  kind_q;
  logic [7:0]      data_q;
  logic            last_q;

  // A waiting item blocks the input only while the sink stalls it.
  assign hold_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!hold_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_o && res_i.valid) begin
      kind_q <= res_i.kind;
      data_q <= res_i.data;
      last_q <= res_i.last;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = kind_q;
  assign data_byte_o   = data_q;
  assign last_o        = last_q;

endmodule

// ===== rtl/core/binary_frame_deframer.sv =====
`timescale 1ns / 1ps

// Byte-stream frame deframer. One byte is taken per cycle whenever the
// output register is empty or its item is taken in the same cycle, so the
// block runs at one byte per clock; the single output register is the only
// pipeline stage. A 28-byte little-endian header is gathered without
// producing results; its last byte yields a header item, last set if the
// length is zero, or an oversize item (last set) when the length exceeds
// the configured maximum, after which the block hunts for the next header.
// Payload bytes follow one result item each, with last on the final one.
// The header fields on the output are read from the header store, which
// holds still while a result waits. The configuration write is always
// ready and must be issued only while the block is idle.
module binary_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [31:0] magic_word_o,
  output logic [15:0] protocol_version_o,
  output logic [15:0] frame_type_o,
  output logic [63:0] timestamp_ns_o,
  output logic [63:0] sequence_number_o,
  output logic [31:0] payload_length_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o
);

  logic                          acc;
  logic                          hold;
  logic                          hdr_we;
  logic [bfd_pkg::HDR_POS_W-1:0] hdr_pos;
  logic [31:0]                   len_next;
  bfd_pkg::hdr_fields_t          fields;
  bfd_pkg::res_t                 res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = hold;
  assign acc         = in_valid_i && !hold;

  bfd_hdr_store u_hdr_store (
    .clk_i      (clk_i),
    .wr_en_i    (hdr_we),
    .wr_pos_i   (hdr_pos),
    .wr_byte_i  (in_byte_i),
    .fields_o   (fields),
    .len_next_o (len_next)
  );

  bfd_frame_ctrl u_frame_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .in_byte_i  (in_byte_i),
    .len_next_i (len_next),
    .hdr_we_o   (hdr_we),
    .hdr_pos_o  (hdr_pos),
    .res_o      (res)
  );

  bfd_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .out_stall_i   (out_stall_i),
    .hold_o        (hold),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .data_byte_o   (data_byte_o),
    .last_o        (last_o)
  );

  assign magic_word_o       = fields.magic_word;
  assign protocol_version_o = fields.protocol_version;
  assign frame_type_o       = fields.frame_type;
  assign timestamp_ns_o     = fields.timestamp_ns;
  assign sequence_number_o  = fields.sequence_number;
  assign payload_length_o   = fields.payload_length;

endmodule
